// ----- hdl/i2crb_pkg.sv -----
// Shared types, codes and constants for the I2C register burst master.
// Used by every module of the block; depends on nothing else.
package i2crb_pkg;

   // Configuration register indexes (word addresses on the CSR port).
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_PHASE_TICKS    = 2'd1;
   localparam logic [1:0] REG_ACK_RETRIES    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd50;
   localparam logic [15:0] PHASE_TICKS_RST    = 16'd4;
   localparam logic [2:0]  ACK_RETRIES_RST    = 3'd3;

   // Error codes reported when a burst ends.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_DEV_W    = 3'd1;
   localparam logic [2:0] ERR_REG      = 3'd2;
   localparam logic [2:0] ERR_DEV_R    = 3'd3;
   localparam logic [2:0] ERR_DATA     = 3'd4;

   // Stream widths.
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 24;

   // Byte in flight on the bus.
   typedef enum logic [1:0] {
      STG_DEV_W = 2'd0,
      STG_REG   = 2'd1,
      STG_DEV_R = 2'd2,
      STG_DATA  = 2'd3
   } stage_type;

   // Bus sequencer states.
   typedef enum logic [4:0] {
      S_IDLE      = 5'd0,
      S_START_HI  = 5'd1,
      S_START_LO  = 5'd2,
      S_TX_LOW    = 5'd3,
      S_TX_HIGH   = 5'd4,
      S_ACK_LOW   = 5'd5,
      S_ACK_HIGH  = 5'd6,
      S_ACK_END   = 5'd7,
      S_REQ       = 5'd8,
      S_LOAD      = 5'd9,
      S_RX_LOW    = 5'd10,
      S_RX_HIGH   = 5'd11,
      S_MACK_LOW  = 5'd12,
      S_MACK_HIGH = 5'd13,
      S_STOP_LOW  = 5'd14,
      S_STOP_HIGH = 5'd15,
      S_STOP_END  = 5'd16
   } seq_state_type;

   // Configuration as seen by the sequencer.
   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] phase_ticks;
      logic [2:0]  ack_retries;
   } cfg_type;

   // One tick item.
   typedef struct packed {
      logic       cmd_valid;
      logic       opcode;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

   // One tick result.
   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       data_request;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic [2:0] error_stage;
   } result_type;

endpackage

// ----- hdl/i2crb_csr.sv -----
// APB-style configuration registers of the I2C register burst master.
// Depends on i2crb_pkg for register indexes and reset values.
module i2crb_csr
   import i2crb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [6:0]  dev_addr_ff, dev_addr_in;
   logic [15:0] phase_ticks_ff, phase_ticks_in;
   logic [2:0]  ack_retries_ff, ack_retries_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[3:2];

   // Register write decode.
   always_comb begin
      dev_addr_in    = dev_addr_ff;
      phase_ticks_in = phase_ticks_ff;
      ack_retries_in = ack_retries_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEVICE_ADDRESS: dev_addr_in    = pwdata[6:0];
            REG_PHASE_TICKS:    phase_ticks_in = pwdata[15:0];
            REG_ACK_RETRIES:    ack_retries_in = pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEVICE_ADDRESS_RST;
         phase_ticks_ff <= PHASE_TICKS_RST;
         ack_retries_ff <= ACK_RETRIES_RST;
      end else begin
         dev_addr_ff    <= dev_addr_in;
         phase_ticks_ff <= phase_ticks_in;
         ack_retries_ff <= ack_retries_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_idx)
         REG_DEVICE_ADDRESS: prdata = {25'd0, dev_addr_ff};
         REG_PHASE_TICKS:    prdata = {16'd0, phase_ticks_ff};
         REG_ACK_RETRIES:    prdata = {29'd0, ack_retries_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg.device_address = dev_addr_ff;
   assign cfg.phase_ticks    = phase_ticks_ff;
   assign cfg.ack_retries    = ack_retries_ff;

endmodule

// ----- hdl/i2crb_seq.sv -----
// Bit-level I2C bus sequencer: advances one tick per processed item.
// Depends on i2crb_pkg for states, stages, item and result types.
module i2crb_seq
   import i2crb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   seq_state_type state_ff, state_in;
   stage_type     stage_ff, stage_in;
   logic [15:0]   pc_ff, pc_in;
   logic [2:0]    bit_ff, bit_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    left_ff, left_in;
   logic [2:0]    retry_ff, retry_in;
   logic          is_read_ff, is_read_in;
   logic [7:0]    saved_reg_ff, saved_reg_in;
   logic [2:0]    perr_ff, perr_in;

   logic [15:0] eff_phase;
   logic [15:0] pc_inc;
   logic        phase_done;
   logic [16:0] pc_inc_wide;
   logic [2:0]  bit_inc;
   logic [7:0]  shift_rx;
   logic        txbit_low;
   logic        mack;

   // Phase timing shared by most states.
   assign eff_phase   = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
   assign pc_inc      = pc_ff + 16'd1;
   assign phase_done  = (pc_inc >= eff_phase);
   assign pc_inc_wide = {1'b0, pc_ff} + 17'd1;
   assign bit_inc     = bit_ff + 3'd1;
   assign shift_rx    = {shift_ff[6:0], item.sda_in};
   assign txbit_low   = ~shift_ff[7];
   assign mack        = (left_ff > 8'd1);

   // Next state and datapath.
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      pc_in        = pc_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      retry_in     = retry_ff;
      is_read_in   = is_read_ff;
      saved_reg_in = saved_reg_ff;
      perr_in      = perr_ff;
      case (state_ff)
         S_IDLE: begin
            if (item.cmd_valid) begin
               is_read_in   = item.opcode;
               saved_reg_in = item.reg_addr;
               left_in      = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
               stage_in     = STG_DEV_W;
               retry_in     = 3'd0;
               perr_in      = ERR_NONE;
               state_in     = S_START_HI;
               pc_in        = 16'd0;
            end
         end
         S_START_HI: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) state_in = S_START_LO;
         end
         S_START_LO: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               shift_in = {cfg.device_address, (stage_ff == STG_DEV_R)};
               bit_in   = 3'd0;
               state_in = S_TX_LOW;
            end
         end
         S_TX_LOW: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) state_in = S_TX_HIGH;
         end
         S_TX_HIGH: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_inc;
               state_in = (bit_inc == 3'd0) ? S_ACK_LOW : S_TX_LOW;
            end
         end
         S_ACK_LOW: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               retry_in = 3'd0;
               state_in = S_ACK_HIGH;
            end
         end
         S_ACK_HIGH: begin
            // Sample SDA at the end of the high phase, with extra retries.
            if (pc_inc_wide < {1'b0, eff_phase}) begin
               pc_in = pc_inc;
            end else if (!item.sda_in) begin
               retry_in = 3'd0;
               state_in = S_ACK_END;
               pc_in    = 16'd0;
            end else if (retry_ff < cfg.ack_retries) begin
               retry_in = retry_ff + 3'd1;
            end else begin
               retry_in = 3'd0;
               perr_in  = {1'b0, stage_ff} + 3'd1;
               state_in = S_STOP_LOW;
               pc_in    = 16'd0;
            end
         end
         S_ACK_END: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               case (stage_ff)
                  STG_DEV_W: begin
                     shift_in = saved_reg_ff;
                     bit_in   = 3'd0;
                     stage_in = STG_REG;
                     state_in = S_TX_LOW;
                  end
                  STG_REG: begin
                     if (is_read_ff) begin
                        stage_in = STG_DEV_R;
                        state_in = S_START_HI;
                     end else begin
                        state_in = S_REQ;
                     end
                  end
                  STG_DEV_R: begin
                     bit_in   = 3'd0;
                     shift_in = 8'd0;
                     state_in = S_RX_LOW;
                  end
                  default: begin
                     left_in  = left_ff - 8'd1;
                     state_in = (left_ff == 8'd1) ? S_STOP_LOW : S_REQ;
                  end
               endcase
            end
         end
         S_REQ: begin
            state_in = S_LOAD;
            pc_in    = 16'd0;
         end
         S_LOAD: begin
            shift_in = item.write_data;
            bit_in   = 3'd0;
            stage_in = STG_DATA;
            state_in = S_TX_LOW;
            pc_in    = 16'd0;
         end
         S_RX_LOW: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) state_in = S_RX_HIGH;
         end
         S_RX_HIGH: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               shift_in = shift_rx;
               bit_in   = bit_inc;
               state_in = (bit_inc == 3'd0) ? S_MACK_LOW : S_RX_LOW;
            end
         end
         S_MACK_LOW: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) state_in = S_MACK_HIGH;
         end
         S_MACK_HIGH: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               left_in  = (left_ff == 8'd0) ? 8'd0 : left_ff - 8'd1;
               shift_in = 8'd0;
               bit_in   = 3'd0;
               state_in = (left_ff <= 8'd1) ? S_STOP_LOW : S_RX_LOW;
            end
         end
         S_STOP_LOW: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) state_in = S_STOP_HIGH;
         end
         S_STOP_HIGH: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) state_in = S_STOP_END;
         end
         S_STOP_END: begin
            pc_in = phase_done ? 16'd0 : pc_inc;
            if (phase_done) begin
               perr_in  = ERR_NONE;
               stage_in = STG_DEV_W;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            pc_in    = 16'd0;
         end
      endcase
   end

   // Pin drive and status for this tick.
   always_comb begin
      result = '0;
      result.busy_res = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:      result.busy_res = item.cmd_valid;
         S_START_HI:  ;
         S_START_LO:  result.sda_pull_low = 1'b1;
         S_TX_LOW: begin
            result.scl_pull_low = 1'b1;
            result.sda_pull_low = txbit_low;
         end
         S_TX_HIGH:   result.sda_pull_low = txbit_low;
         S_ACK_LOW:   result.scl_pull_low = 1'b1;
         S_ACK_HIGH:  ;
         S_ACK_END:   result.scl_pull_low = 1'b1;
         S_REQ: begin
            result.scl_pull_low = 1'b1;
            result.data_request = 1'b1;
         end
         S_LOAD:      result.scl_pull_low = 1'b1;
         S_RX_LOW:    result.scl_pull_low = 1'b1;
         S_RX_HIGH: begin
            if (phase_done && bit_inc == 3'd0) begin
               result.read_valid = 1'b1;
               result.read_byte  = shift_rx;
               result.read_last  = (left_ff <= 8'd1);
            end
         end
         S_MACK_LOW: begin
            result.scl_pull_low = 1'b1;
            result.sda_pull_low = mack;
         end
         S_MACK_HIGH: result.sda_pull_low = mack;
         S_STOP_LOW: begin
            result.scl_pull_low = 1'b1;
            result.sda_pull_low = 1'b1;
         end
         S_STOP_HIGH: result.sda_pull_low = 1'b1;
         S_STOP_END: begin
            if (phase_done) begin
               result.done_res    = 1'b1;
               result.error_stage = perr_ff;
            end
         end
         default:     result.busy_res = 1'b0;
      endcase
   end

   // Sequencer state advances once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= STG_DEV_W;
         pc_ff        <= 16'd0;
         bit_ff       <= 3'd0;
         shift_ff     <= 8'd0;
         left_ff      <= 8'd0;
         retry_ff     <= 3'd0;
         is_read_ff   <= 1'b0;
         saved_reg_ff <= 8'd0;
         perr_ff      <= ERR_NONE;
      end else if (advance) begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         pc_ff        <= pc_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         retry_ff     <= retry_in;
         is_read_ff   <= is_read_in;
         saved_reg_ff <= saved_reg_in;
         perr_ff      <= perr_in;
      end
   end

endmodule

// ----- hdl/i2c_register_burst_master_unit.sv -----
// Top level of the I2C register burst master: input register, sequencer, result register.
// Depends on i2crb_pkg, i2crb_csr and i2crb_seq.
//
// Usage: each transfer on the req_ stream is one bus tick. It carries the command
// fields (used only when the sequencer is idle), the next write byte and the
// sampled SDA level. Each tick produces exactly one transfer on the rsp_ stream
// with the SCL/SDA pull-low drives, busy, data request, received byte and the
// done flag with its error stage. rsp_tlast marks the final byte of a read burst.
// A req_ item waits in the input register, then passes through the sequencer into the
// result register, from which the rsp_ item is offered. Throughput is one item
// per clock while the rsp_ side keeps rsp_tready high; the sequencer's state
// registers are the only loop.
// When rsp_tready is low while a result is offered, the result register holds,
// the sequencer does not advance, and req_tready drops once the input register is full.
// Reset empties both registers, returns the sequencer to idle and loads the
// configuration defaults (device address 50, 4 ticks per phase, 3 retries).
// The user writes the csr_ port only while the block is idle; nothing enforces it.
module i2c_register_burst_master_unit
   import i2crb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req tdata: cmd_valid[0], reg_addr[8:1], byte_count[16:9], write_data[24:17],
   // sda_in[25], zero padding[31:26]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req tuser: opcode[0]
   input  logic                  req_tuser,
   // rsp tdata: scl_pull_low[0], sda_pull_low[1], busy_res[2], data_request[3],
   // read_byte[11:4], read_valid[12], done_res[13], error_stage[16:14], zero[23:17]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff;
   result_type seq_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   i2crb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // The held item moves into the result register when that register frees up.
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;

   // Unpack the request transfer.
   assign item_in.cmd_valid  = req_tdata[0];
   assign item_in.opcode     = req_tuser;
   assign item_in.reg_addr   = req_tdata[8:1];
   assign item_in.byte_count = req_tdata[16:9];
   assign item_in.write_data = req_tdata[24:17];
   assign item_in.sda_in     = req_tdata[25];

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   i2crb_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (seq_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= seq_result;
      end
   end

   // Pack the result transfer.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.read_last;
   assign rsp_tdata  = {7'd0, rsp_ff.error_stage, rsp_ff.done_res, rsp_ff.read_valid,
                        rsp_ff.read_byte, rsp_ff.data_request, rsp_ff.busy_res,
                        rsp_ff.sda_pull_low, rsp_ff.scl_pull_low};

endmodule

// ----- tb/sv/i2c_register_burst_master_unit_test.sv -----
// Self-checking testbench for the I2C register burst master: drives bus ticks on the
// req_ stream, predicts every rsp_ transfer and compares it field by field.
// Depends on i2crb_pkg and the i2c_register_burst_master_unit top level.
module i2c_register_burst_master_unit_test;
   import i2crb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned PRINT_LIMIT   = 40;

   // Tick-accurate model of the bus sequencer and the queue of results it predicts.
   class tick_scoreboard;
      cfg_type       cfg;
      seq_state_type seq_state;
      logic [15:0]   phase_cnt;
      logic [2:0]    bit_idx;
      logic [7:0]    shifter;
      logic [7:0]    bytes_left;
      logic [2:0]    retry_cnt;
      logic          is_read;
      logic [7:0]    saved_reg;
      stage_type     stage;
      logic [2:0]    pending_err;
      result_type    expected_ticks[$];
      int unsigned   mismatches;

      function new();
         cfg.device_address = DEVICE_ADDRESS_RST;
         cfg.phase_ticks    = PHASE_TICKS_RST;
         cfg.ack_retries    = ACK_RETRIES_RST;
         seq_state   = S_IDLE;
         phase_cnt   = '0;
         bit_idx     = '0;
         shifter     = '0;
         bytes_left  = '0;
         retry_cnt   = '0;
         is_read     = 1'b0;
         saved_reg   = '0;
         stage       = STG_DEV_W;
         pending_err = ERR_NONE;
         mismatches  = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_DEVICE_ADDRESS: cfg.device_address = value[6:0];
            REG_PHASE_TICKS:    cfg.phase_ticks    = value[15:0];
            REG_ACK_RETRIES:    cfg.ack_retries    = value[2:0];
            default: ;
         endcase
      endfunction

      // A phase length of zero behaves as one tick.
      function int unsigned phase_len();
         if (cfg.phase_ticks == 16'd0) return 1;
         return {16'd0, cfg.phase_ticks};
      endfunction

      // Counts one tick of the current phase; returns 1 when the phase has ended.
      function bit phase_done();
         phase_cnt = phase_cnt + 16'd1;
         if ({16'd0, phase_cnt} >= phase_len()) begin
            phase_cnt = '0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void enter(seq_state_type nxt);
         seq_state = nxt;
         phase_cnt = '0;
      endfunction

      function void load_byte(logic [7:0] value, stage_type st);
         shifter = value;
         bit_idx = '0;
         stage   = st;
         enter(S_TX_LOW);
      endfunction

      // Advances the model by one accepted tick and queues the result it produces.
      function void note_tick(item_type it);
         result_type r;
         logic       tx_low;
         logic       mack;
         r = '0;
         tx_low = ~shifter[7];
         mack = (bytes_left > 8'd1);
         r.busy_res = (seq_state != S_IDLE);
         case (seq_state)
            S_IDLE: begin
               if (it.cmd_valid) begin
                  is_read     = it.opcode;
                  saved_reg   = it.reg_addr;
                  bytes_left  = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
                  stage       = STG_DEV_W;
                  retry_cnt   = '0;
                  pending_err = ERR_NONE;
                  r.busy_res  = 1'b1;
                  enter(S_START_HI);
               end
            end
            S_START_HI: begin
               if (phase_done()) enter(S_START_LO);
            end
            S_START_LO: begin
               r.sda_pull_low = 1'b1;
               if (phase_done()) load_byte({cfg.device_address, stage == STG_DEV_R}, stage);
            end
            S_TX_LOW: begin
               r.scl_pull_low = 1'b1;
               r.sda_pull_low = tx_low;
               if (phase_done()) enter(S_TX_HIGH);
            end
            S_TX_HIGH: begin
               r.sda_pull_low = tx_low;
               if (phase_done()) begin
                  shifter = shifter << 1;
                  bit_idx = bit_idx + 3'd1;
                  if (bit_idx == 3'd0) enter(S_ACK_LOW);
                  else enter(S_TX_LOW);
               end
            end
            S_ACK_LOW: begin
               r.scl_pull_low = 1'b1;
               if (phase_done()) begin
                  retry_cnt = '0;
                  enter(S_ACK_HIGH);
               end
            end
            S_ACK_HIGH: begin
               // The slot samples SDA only once the high phase is over, then retries.
               if ({16'd0, phase_cnt} + 1 < phase_len()) begin
                  phase_cnt = phase_cnt + 16'd1;
               end else if (!it.sda_in) begin
                  retry_cnt = '0;
                  enter(S_ACK_END);
               end else if (retry_cnt < cfg.ack_retries) begin
                  retry_cnt = retry_cnt + 3'd1;
               end else begin
                  retry_cnt = '0;
                  case (stage)
                     STG_DEV_W: pending_err = ERR_DEV_W;
                     STG_REG:   pending_err = ERR_REG;
                     STG_DEV_R: pending_err = ERR_DEV_R;
                     default:   pending_err = ERR_DATA;
                  endcase
                  enter(S_STOP_LOW);
               end
            end
            S_ACK_END: begin
               r.scl_pull_low = 1'b1;
               if (phase_done()) begin
                  case (stage)
                     STG_DEV_W: load_byte(saved_reg, STG_REG);
                     STG_REG: begin
                        if (is_read) begin
                           stage = STG_DEV_R;
                           enter(S_START_HI);
                        end else begin
                           enter(S_REQ);
                        end
                     end
                     STG_DEV_R: begin
                        bit_idx = '0;
                        shifter = '0;
                        enter(S_RX_LOW);
                     end
                     default: begin
                        bytes_left = bytes_left - 8'd1;
                        if (bytes_left == 8'd0) enter(S_STOP_LOW);
                        else enter(S_REQ);
                     end
                  endcase
               end
            end
            S_REQ: begin
               r.scl_pull_low = 1'b1;
               r.data_request = 1'b1;
               enter(S_LOAD);
            end
            S_LOAD: begin
               r.scl_pull_low = 1'b1;
               load_byte(it.write_data, STG_DATA);
            end
            S_RX_LOW: begin
               r.scl_pull_low = 1'b1;
               if (phase_done()) enter(S_RX_HIGH);
            end
            S_RX_HIGH: begin
               if (phase_done()) begin
                  shifter = {shifter[6:0], it.sda_in};
                  bit_idx = bit_idx + 3'd1;
                  if (bit_idx == 3'd0) begin
                     r.read_valid = 1'b1;
                     r.read_byte  = shifter;
                     r.read_last  = (bytes_left <= 8'd1);
                     enter(S_MACK_LOW);
                  end else begin
                     enter(S_RX_LOW);
                  end
               end
            end
            S_MACK_LOW: begin
               r.scl_pull_low = 1'b1;
               r.sda_pull_low = mack;
               if (phase_done()) enter(S_MACK_HIGH);
            end
            S_MACK_HIGH: begin
               r.sda_pull_low = mack;
               if (phase_done()) begin
                  if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
                  shifter = '0;
                  bit_idx = '0;
                  if (bytes_left == 8'd0) enter(S_STOP_LOW);
                  else enter(S_RX_LOW);
               end
            end
            S_STOP_LOW: begin
               r.scl_pull_low = 1'b1;
               r.sda_pull_low = 1'b1;
               if (phase_done()) enter(S_STOP_HIGH);
            end
            S_STOP_HIGH: begin
               r.sda_pull_low = 1'b1;
               if (phase_done()) enter(S_STOP_END);
            end
            S_STOP_END: begin
               if (phase_done()) begin
                  r.done_res    = 1'b1;
                  r.error_stage = pending_err;
                  pending_err   = ERR_NONE;
                  stage         = STG_DEV_W;
                  enter(S_IDLE);
               end
            end
            default: enter(S_IDLE);
         endcase
         expected_ticks.push_back(r);
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Checks one received result transfer against the oldest prediction.
      function void check_tick(result_type got);
         result_type want;
         if (expected_ticks.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: result transfer with nothing pending, expected none, actual %h",
                        $time, got);
            return;
         end
         want = expected_ticks.pop_front();
         compare("scl_pull_low", 32'(want.scl_pull_low), 32'(got.scl_pull_low));
         compare("sda_pull_low", 32'(want.sda_pull_low), 32'(got.sda_pull_low));
         compare("busy_res",     32'(want.busy_res),     32'(got.busy_res));
         compare("data_request", 32'(want.data_request), 32'(got.data_request));
         compare("read_byte",    32'(want.read_byte),    32'(got.read_byte));
         compare("read_valid",   32'(want.read_valid),   32'(got.read_valid));
         compare("read_last",    32'(want.read_last),    32'(got.read_last));
         compare("done_res",     32'(want.done_res),     32'(got.done_res));
         compare("error_stage",  32'(want.error_stage),  32'(got.error_stage));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   tick_scoreboard sb = new();

   // Behavior of the emulated target in acknowledge slots.
   bit          nack_on;
   stage_type   nack_stage;
   int unsigned nack_left;
   int unsigned hold_pct;

   // Remaining transfers of a stretch without idle cycles, per side.
   int unsigned tx_calm;
   int unsigned rx_calm;

   i2c_register_burst_master_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle cycles before the next transfer: mostly 0 to 12, sometimes a run of none.
   function automatic int unsigned draw_wait(ref int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic void set_target(bit on, stage_type st, int unsigned left,
                                      int unsigned hold);
      nack_on    = on;
      nack_stage = st;
      nack_left  = left;
      hold_pct   = hold;
   endfunction

   function automatic void draw_target();
      set_target($urandom_range(0, 3) == 0, stage_type'($urandom_range(0, 3)),
                 $urandom_range(1, 6), $urandom_range(0, 2) * 25);
   endfunction

   // Builds the next tick for the sequencer state it will meet. SDA follows the
   // emulated target in acknowledge slots and is random everywhere else.
   function automatic item_type make_tick(bit may_start);
      item_type    it;
      int unsigned pick;
      it.cmd_valid  = 1'($urandom_range(0, 1));
      it.opcode     = 1'($urandom_range(0, 1));
      it.reg_addr   = 8'($urandom_range(0, 255));
      it.byte_count = 8'($urandom_range(0, 255));
      it.write_data = 8'($urandom_range(0, 255));
      if (sb.seq_state == S_IDLE) begin
         it.cmd_valid = may_start && ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) it.byte_count = 8'd0;
         else if (pick < 95) it.byte_count = 8'($urandom_range(1, 6));
         else it.byte_count = 8'($urandom_range(7, 40));
      end
      if (sb.seq_state == S_ACK_HIGH) begin
         if (nack_on && sb.stage == nack_stage && sb.bytes_left <= nack_left)
            it.sda_in = 1'b1;
         else
            it.sda_in = ($urandom_range(0, 99) < hold_pct);
      end else begin
         it.sda_in = 1'($urandom_range(0, 1));
      end
      return it;
   endfunction

   // Offers one tick on the req_ stream and records it once the transfer happens.
   task automatic send_tick(input item_type it);
      int unsigned gap;
      gap = draw_wait(tx_calm);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, it.sda_in, it.write_data, it.byte_count, it.reg_addr,
                     it.cmd_valid};
      req_tuser  <= it.opcode;
      do @(posedge clock); while (!req_tready);
      sb.note_tick(it);
   endtask

   // Holds off the sender until every predicted result has been received.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup and access cycles of a register write.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Starts one burst, then keeps ticking with ignored command noise until it ends.
   task automatic run_burst(input bit op, input logic [7:0] reg_a, input logic [7:0] cnt);
      item_type it;
      it = make_tick(1'b0);
      it.cmd_valid  = 1'b1;
      it.opcode     = op;
      it.reg_addr   = reg_a;
      it.byte_count = cnt;
      send_tick(it);
      while (sb.seq_state != S_IDLE) send_tick(make_tick(1'b0));
   endtask

   // Random bursts with random target behavior; the last burst is run to its end.
   task automatic run_random(input int unsigned n);
      item_type it;
      repeat (n) begin
         it = make_tick(1'b1);
         if (it.cmd_valid && sb.seq_state == S_IDLE) draw_target();
         if ($urandom_range(0, 299) == 0) wait_drained();
         send_tick(it);
      end
      while (sb.seq_state != S_IDLE) send_tick(make_tick(1'b0));
   endtask

   // Result side: random stalls, each transfer checked at the edge it happens on.
   initial begin
      result_type got;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         repeat (draw_wait(rx_calm)) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.scl_pull_low = rsp_tdata[0];
         got.sda_pull_low = rsp_tdata[1];
         got.busy_res     = rsp_tdata[2];
         got.data_request = rsp_tdata[3];
         got.read_byte    = rsp_tdata[11:4];
         got.read_valid   = rsp_tdata[12];
         got.done_res     = rsp_tdata[13];
         got.error_stage  = rsp_tdata[16:14];
         got.read_last    = rsp_tlast;
         sb.check_tick(got);
      end
   end

   // Watchdog on the whole run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("i2c_register_burst_master_unit_test NOT OK");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      tx_calm     = 0;
      rx_calm     = 0;
      set_target(1'b0, STG_DEV_W, 0, 0);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default configuration: a clean write and a clean read.
      run_burst(1'b0, 8'h00, 8'd1);
      run_burst(1'b1, 8'hFF, 8'd2);
      wait_drained();

      // Highest address, one-tick phases, no retries: every error stage.
      write_csr(REG_DEVICE_ADDRESS, 32'd127);
      write_csr(REG_PHASE_TICKS, 32'd1);
      write_csr(REG_ACK_RETRIES, 32'd0);
      run_burst(1'b0, 8'h5A, 8'd0);
      set_target(1'b1, STG_DEV_W, 255, 0);
      run_burst(1'b0, 8'h12, 8'd1);
      set_target(1'b1, STG_REG, 255, 0);
      run_burst(1'b0, 8'h34, 8'd2);
      set_target(1'b1, STG_DEV_R, 255, 0);
      run_burst(1'b1, 8'h56, 8'd1);
      // The second of three data bytes is refused.
      set_target(1'b1, STG_DATA, 2, 0);
      run_burst(1'b0, 8'h78, 8'd3);
      // The largest byte count, refused at its first data byte.
      set_target(1'b1, STG_DATA, 255, 0);
      run_burst(1'b0, 8'hA5, 8'd255);
      set_target(1'b0, STG_DEV_W, 0, 0);
      wait_drained();

      // Address zero, zero phase length, most retries.
      write_csr(REG_DEVICE_ADDRESS, 32'd0);
      write_csr(REG_PHASE_TICKS, 32'd0);
      write_csr(REG_ACK_RETRIES, 32'd7);
      set_target(1'b0, STG_DEV_W, 0, 60);
      run_burst(1'b0, 8'hC3, 8'd2);
      set_target(1'b1, STG_DEV_W, 255, 0);
      run_burst(1'b0, 8'h3C, 8'd1);
      set_target(1'b0, STG_DEV_W, 0, 30);
      run_burst(1'b1, 8'h81, 8'd3);
      wait_drained();

      // Longest phase: idle ticks only, as a burst would outlast the watchdog.
      write_csr(REG_PHASE_TICKS, 32'd65535);
      repeat (20) send_tick(make_tick(1'b0));
      wait_drained();

      // A longer phase with one retry, refused at the write address.
      write_csr(REG_PHASE_TICKS, 32'd7);
      write_csr(REG_ACK_RETRIES, 32'd1);
      set_target(1'b1, STG_DEV_W, 255, 0);
      run_burst(1'b0, 8'h66, 8'd1);
      wait_drained();

      // Random bursts under two short-phase settings.
      for (int p = 0; p < 2; p++) begin
         write_csr(REG_DEVICE_ADDRESS, $urandom_range(0, 127));
         write_csr(REG_PHASE_TICKS, p % 3 + 1);
         write_csr(REG_ACK_RETRIES, $urandom_range(0, 7));
         run_random(80);
         wait_drained();
      end

      if (sb.mismatches == 0 && sb.expected_ticks.size() == 0)
         $display("i2c_register_burst_master_unit_test OK");
      else
         $display("i2c_register_burst_master_unit_test NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/i2crb_pkg.sv
hdl/i2crb_csr.sv
hdl/i2crb_seq.sv
hdl/i2c_register_burst_master_unit.sv
tb/sv/i2c_register_burst_master_unit_test.sv
